// ===== sv/b3h_pkg.sv =====
`default_nettype none
package b3h_pkg;
  localparam int BlockBytes = 64;
  localparam int ChunkBlocks = 16;
  localparam int RoundCount = 7;
  localparam logic [31:0] FlagBegin = 32'd1;
  localparam logic [31:0] FlagFinish = 32'd2;
  localparam logic [31:0] FlagTop = 32'd8;
  localparam int QueueDepth = 4;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] cv_t;
  typedef word_t [15:0] blk_t;

  localparam cv_t InitVec = {32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
                             32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

  // One queued beat: word with its clipped byte count and last mark.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  count;
    logic        last;
  } beat_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_COMP,
    ST_EMIT
  } state_e;

  function automatic logic [3:0] perm_idx(input logic [2:0] r, input logic [3:0] k);
    logic [3:0] p [16];
    logic [3:0] x;
    p = '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
          4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};
    x = k;
    for (int i = 0; i < 6; i++) begin
      if (3'(i) < r) x = p[x];
    end
    return x;
  endfunction
endpackage
`default_nettype wire

// ===== sv/blake3_single_chunk_hash.sv =====
`default_nettype none
// Single-chunk BLAKE3 hash (unkeyed). Message beats of one 32-bit little-endian word, a byte
// count (values above four count as four) and a last mark enter a four-beat queue, so the
// input takes one beat per cycle while the queue has room. The back end packs bytes into a
// 64-byte block and runs the seven-round compression at half a round per cycle; a full block
// is compressed only when more bytes follow. After the last beat it compresses the padded
// final block with the end-of-chunk and root flags and emits digest_words beats (1 to 16,
// reset 8), the final one with last_word set. Bytes past 1024 are dropped and every digest
// beat of that message carries too_long. The back end takes no beats while it compresses, so
// it sets the rate: one beat per cycle within a block, halted at each block boundary while
// that block is compressed. Each message then adds the final compression and the digest
// beats, one per cycle unless the output stalls. Write the configuration register only
// while idle.
module blake3_single_chunk_hash
  import b3h_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] message_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_item_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic             last_word_o,
  output logic             too_long_o
);
  logic q_valid, q_pop;
  beat_t q_beat;

  b3h_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .message_word_i, .byte_count_i, .last_item_i,
    .q_valid_o(q_valid), .q_beat_o(q_beat), .q_pop_i(q_pop)
  );

  b3h_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .q_valid_i(q_valid), .q_beat_i(q_beat), .q_pop_o(q_pop),
    .valid_o, .stall_i, .digest_word_o, .last_word_o, .too_long_o
  );
endmodule
`default_nettype wire

// ===== sv/b3h_front.sv =====
`default_nettype none
module b3h_front
  import b3h_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [31:0] message_word_i,
  input  wire logic [2:0]  byte_count_i,
  input  wire logic        last_item_i,
  output logic             q_valid_o,
  output beat_t            q_beat_o,
  input  wire logic        q_pop_i
);
  localparam int PtrW = $clog2(QueueDepth);
  beat_t mem_q [QueueDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0] cnt_q;
  logic push;
  beat_t nb;

  assign stall_o = (cnt_q == (PtrW+1)'(QueueDepth));
  assign push = valid_i && !stall_o;
  always_comb begin
    nb.word = message_word_i;
    nb.count = (byte_count_i > 3'd4) ? 3'd4 : byte_count_i;
    nb.last = last_item_i;
  end
  assign q_valid_o = (cnt_q != '0);
  assign q_beat_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= nb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (q_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
    end
  end
endmodule
`default_nettype wire

// ===== sv/b3h_back.sv =====
`default_nettype none
module b3h_back
  import b3h_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        q_valid_i,
  input  wire beat_t       q_beat_i,
  output logic             q_pop_o,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic             last_word_o,
  output logic             too_long_o
);
  state_e st_q, st_d;
  cv_t cv_q;
  blk_t buf_q;
  logic [6:0] nbytes_q;
  logic [4:0] blocks_q;
  logic ovf_q;
  logic [4:0] dw_q;
  word_t [15:0] v_q;
  logic [2:0] rnd_q;
  logic step_q;
  logic fin_q;
  blk_t res_q;
  logic [3:0] oidx_q;
  logic [2:0] skip_q;
  logic [4:0] n_eff;

  assign n_eff = (dw_q == 5'd0) ? 5'd1 : ((dw_q > 5'd16) ? 5'd16 : dw_q);

  // Buffered bytes plus the rest of the head beat, and whether the chunk is on its last block.
  logic room_blocked;
  logic [7:0] want_bytes;
  assign room_blocked = (blocks_q + 5'd1 >= 5'(ChunkBlocks));
  assign want_bytes = {1'b0, nbytes_q} + {5'd0, q_beat_i.count - skip_q};

  function automatic word_t rr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void gmix(inout word_t a, inout word_t b, inout word_t c,
                               inout word_t d, input word_t x, input word_t y);
    a = a + b + x; d = rr(d ^ a, 16); c = c + d; b = rr(b ^ c, 12);
    a = a + b + y; d = rr(d ^ a, 8);  c = c + d; b = rr(b ^ c, 7);
  endfunction

  // Half a round per cycle: columns then diagonals.
  word_t [15:0] v_n;
  always_comb begin
    v_n = v_q;
    if (!step_q) begin
      for (int g = 0; g < 4; g++) begin
        gmix(v_n[g], v_n[g+4], v_n[g+8], v_n[g+12],
             buf_q[perm_idx(rnd_q, 4'(2*g))], buf_q[perm_idx(rnd_q, 4'(2*g+1))]);
      end
    end else begin
      gmix(v_n[0], v_n[5], v_n[10], v_n[15],
           buf_q[perm_idx(rnd_q, 4'd8)], buf_q[perm_idx(rnd_q, 4'd9)]);
      gmix(v_n[1], v_n[6], v_n[11], v_n[12],
           buf_q[perm_idx(rnd_q, 4'd10)], buf_q[perm_idx(rnd_q, 4'd11)]);
      gmix(v_n[2], v_n[7], v_n[8], v_n[13],
           buf_q[perm_idx(rnd_q, 4'd12)], buf_q[perm_idx(rnd_q, 4'd13)]);
      gmix(v_n[3], v_n[4], v_n[9], v_n[14],
           buf_q[perm_idx(rnd_q, 4'd14)], buf_q[perm_idx(rnd_q, 4'd15)]);
    end
  end
  logic comp_done;
  assign comp_done = step_q && (rnd_q == 3'(RoundCount - 1));

  // Fill: when the rest of the head beat does not fit and there is room in the
  // chunk, the bytes that fit are packed and the full block is compressed before
  // the remaining bytes of that beat are taken.
  logic need_comp, take_beat;
  assign need_comp = q_valid_i && !room_blocked && (want_bytes > 8'(BlockBytes));
  assign take_beat = (st_q == ST_FILL) && q_valid_i && !need_comp;
  assign q_pop_o = take_beat;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_FILL: if (need_comp || (take_beat && q_beat_i.last)) st_d = ST_COMP;
      ST_COMP: if (comp_done) st_d = fin_q ? ST_EMIT : ST_FILL;
      ST_EMIT: if (!stall_i && (5'(oidx_q) + 5'd1 == n_eff)) st_d = ST_FILL;
      default: st_d = ST_FILL;
    endcase
  end

  always_comb begin
    valid_o = (st_q == ST_EMIT);
    digest_word_o = res_q[oidx_q];
    last_word_o = (5'(oidx_q) + 5'd1 == n_eff);
    too_long_o = ovf_q;
  end

  // Pack the beat's bytes one after another into the buffer.
  blk_t buf_p;
  logic [6:0] nb_p;
  logic ovf_p;
  always_comb begin
    buf_p = buf_q;
    nb_p = nbytes_q;
    ovf_p = ovf_q;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) >= skip_q && 3'(i) < q_beat_i.count) begin
        if (nb_p == 7'(BlockBytes)) begin
          if (room_blocked) ovf_p = 1'b1;
        end else begin
          buf_p[nb_p[5:2]][8*nb_p[1:0] +: 8] = q_beat_i.word[8*i +: 8];
          nb_p = nb_p + 7'd1;
        end
      end
    end
  end

  word_t [15:0] v_init;
  always_comb begin
    v_init[7:0] = cv_q;
    v_init[11:8] = InitVec[3:0];
    v_init[12] = '0;
    v_init[13] = '0;
    v_init[14] = 32'(BlockBytes);
    v_init[15] = (blocks_q == '0) ? FlagBegin : '0;
    if (take_beat) begin
      v_init[14] = 32'(nb_p);
      v_init[15] = FlagFinish | FlagTop | ((blocks_q == '0) ? FlagBegin : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_FILL) begin
      v_q <= v_init;
    end else if (st_q == ST_COMP) begin
      v_q <= v_n;
    end
    if (st_q == ST_COMP && comp_done && fin_q) begin
      for (int i = 0; i < 8; i++) begin
        res_q[i] <= v_n[i] ^ v_n[i+8];
        res_q[i+8] <= v_n[i+8] ^ cv_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_FILL;
      cv_q <= InitVec;
      buf_q <= '0;
      nbytes_q <= '0;
      blocks_q <= '0;
      ovf_q <= 1'b0;
      dw_q <= 5'd8;
      rnd_q <= '0;
      step_q <= 1'b0;
      fin_q <= 1'b0;
      oidx_q <= '0;
      skip_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) dw_q <= cfg_wdata_i;
      unique case (st_q)
        ST_FILL: begin
          rnd_q <= '0;
          step_q <= 1'b0;
          oidx_q <= '0;
          fin_q <= take_beat && q_beat_i.last;
          if (take_beat) begin
            buf_q <= buf_p;
            nbytes_q <= nb_p;
            ovf_q <= ovf_p;
            skip_q <= '0;
          end else if (need_comp) begin
            buf_q <= buf_p;
            nbytes_q <= nb_p;
            skip_q <= skip_q + 3'(nb_p - nbytes_q);
          end
        end
        ST_COMP: begin
          step_q <= !step_q;
          if (step_q) rnd_q <= rnd_q + 3'd1;
          if (comp_done && !fin_q) begin
            for (int i = 0; i < 8; i++) cv_q[i] <= v_n[i] ^ v_n[i+8];
            buf_q <= '0;
            nbytes_q <= '0;
            blocks_q <= blocks_q + 5'd1;
          end
        end
        ST_EMIT: begin
          if (!stall_i) begin
            oidx_q <= oidx_q + 4'd1;
            if (5'(oidx_q) + 5'd1 == n_eff) begin
              cv_q <= InitVec;
              buf_q <= '0;
              nbytes_q <= '0;
              blocks_q <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
